// ===== rtl/core/bpc_pkg.sv =====
// shared types, constants and register codes of the button press classifier
package bpc_pkg;

  localparam int NUM_BUTTONS  = 3;
  localparam int TIME_BITS    = 16;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int EV_BITS      = 3;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = CFG_BITS'(50);
  localparam logic [CFG_BITS-1:0] POLL_RESET     = CFG_BITS'(10);
  localparam logic [CFG_BITS-1:0] QUICK_RESET    = CFG_BITS'(300);
  localparam logic [CFG_BITS-1:0] LONG_RESET     = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] HELD_RESET     = CFG_BITS'(200);
  // poll_ms reduced modulo held_ms at reset
  localparam logic [CFG_BITS-1:0] PMOD_RESET     = CFG_BITS'(10 % 200);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEBOUNCE = 3'd0,
    REG_POLL     = 3'd1,
    REG_QUICK    = 3'd2,
    REG_LONG     = 3'd3,
    REG_HELD     = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_DEB_PRESS = 3'd1,
    PH_QUICK     = 3'd2,
    PH_LONG      = 3'd3,
    PH_HELD      = 3'd4,
    PH_DEB_REL   = 3'd5
  } phase_e;

  typedef enum logic [EV_BITS-1:0] {
    EV_NONE    = 3'd0,
    EV_QUICK   = 3'd1,
    EV_LONG    = 3'd2,
    EV_HELD    = 3'd3,
    EV_RELEASE = 3'd4
  } event_e;

  typedef struct packed {
    logic up_level;
    logic enter_level;
    logic down_level;
    logic up_edge;
    logic enter_edge;
    logic down_edge;
  } in_beat_t;

  typedef struct packed {
    logic [EV_BITS-1:0] up_event;
    logic [EV_BITS-1:0] enter_event;
    logic [EV_BITS-1:0] down_event;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce;
    logic [CFG_BITS-1:0] poll;
    logic [CFG_BITS-1:0] quick;
    logic [CFG_BITS-1:0] long_ms;
    logic [CFG_BITS-1:0] held;
    logic [CFG_BITS-1:0] pmod;
  } cfg_t;

  // sequencing of the serial remainder pass
  typedef struct packed {
    logic busy;
    logic load;
    logic last;
  } red_ctrl_t;

endpackage

// ===== rtl/core/button_press_classifier.sv =====
// top level of the button press classifier: config registers, lanes, merge
//
//   channel   direction  handshake               payload
//   --------  ---------  ----------------------  ---------------------
//   in        input      in_valid_i / in_stall_o   bpc_pkg::in_beat_t
//   out       output     out_valid_o / out_stall_i bpc_pkg::out_beat_t
//   cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// one poll tick is taken every cycle that in_stall_o is low; its event
// beat shows in the output register on the next cycle, and no new tick
// enters while it waits stalled. a write to poll_ms or held_ms starts the
// serial remainder unit; in_stall_o stays high for its load, one bit per cycle
// reset is asynchronous: all lanes go inactive, config takes its defaults
// in_stall_o rises in a config write cycle, during the remainder pass, and
// when the output register is full and stalled
module button_press_classifier #(
  parameter int TimeBits = bpc_pkg::TIME_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  bpc_pkg::in_beat_t                    in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output bpc_pkg::out_beat_t                   out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [bpc_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [bpc_pkg::CFG_BITS-1:0]         cfg_data_i
);

  localparam int NB = bpc_pkg::NUM_BUTTONS;
  localparam int CB = bpc_pkg::CFG_BITS;

  // config registers
  logic [CB-1:0] debounce_q;
  logic [CB-1:0] poll_q;
  logic [CB-1:0] quick_q;
  logic [CB-1:0] long_q;
  logic [CB-1:0] held_q;

  logic                                 tick;
  logic                                 red_start;
  logic [CB-1:0]                        pmod;
  bpc_pkg::red_ctrl_t                   red_ctrl;
  bpc_pkg::cfg_t                        lane_cfg;
  logic [NB-1:0]                        level;
  logic [NB-1:0]                        edge_seen;
  bpc_pkg::event_e [NB-1:0]             lane_ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= bpc_pkg::DEBOUNCE_RESET;
      poll_q     <= bpc_pkg::POLL_RESET;
      quick_q    <= bpc_pkg::QUICK_RESET;
      long_q     <= bpc_pkg::LONG_RESET;
      held_q     <= bpc_pkg::HELD_RESET;
    end else if (cfg_we_i) begin
      case (bpc_pkg::cfg_reg_e'(cfg_idx_i))
        bpc_pkg::REG_DEBOUNCE: debounce_q <= cfg_data_i;
        bpc_pkg::REG_POLL:     poll_q     <= cfg_data_i;
        bpc_pkg::REG_QUICK:    quick_q    <= cfg_data_i;
        bpc_pkg::REG_LONG:     long_q     <= cfg_data_i;
        bpc_pkg::REG_HELD:     held_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // the held step and the stored remainders must be re-reduced
  assign red_start = cfg_we_i &&
                     ((bpc_pkg::cfg_reg_e'(cfg_idx_i) == bpc_pkg::REG_POLL) ||
                      (bpc_pkg::cfg_reg_e'(cfg_idx_i) == bpc_pkg::REG_HELD));

  bpc_poll_mod u_poll_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .poll_i  (poll_q),
    .held_i  (held_q),
    .ctrl_o  (red_ctrl),
    .pmod_o  (pmod)
  );

  assign lane_cfg.debounce = debounce_q;
  assign lane_cfg.poll     = poll_q;
  assign lane_cfg.quick    = quick_q;
  assign lane_cfg.long_ms  = long_q;
  assign lane_cfg.held     = held_q;
  assign lane_cfg.pmod     = pmod;

  // accept while no config write or remainder pass is under way and the output register can take a beat this cycle
  assign in_stall_o = red_ctrl.busy || cfg_we_i || (out_valid_o && out_stall_i);
  assign tick       = in_valid_i && !in_stall_o;

  // lane 0 up, lane 1 enter, lane 2 down
  assign level     = {in_data_i.down_level, in_data_i.enter_level, in_data_i.up_level};
  assign edge_seen = {in_data_i.down_edge, in_data_i.enter_edge, in_data_i.up_edge};

  for (genvar b = 0; b < NB; b++) begin : g_lane
    bpc_lane #(
      .TimeBits (TimeBits)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (tick),
      .level_i (level[b]),
      .edge_i  (edge_seen[b]),
      .cfg_i   (lane_cfg),
      .ctrl_i  (red_ctrl),
      .event_o (lane_ev[b])
    );
  end

  bpc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (tick),
    .ev_i        (lane_ev),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/bpc_poll_mod.sv =====
// serial remainder unit: poll_ms modulo held_ms, and sequencing for the lanes
module bpc_poll_mod (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [bpc_pkg::CFG_BITS-1:0]     poll_i,
  input  logic [bpc_pkg::CFG_BITS-1:0]     held_i,
  output bpc_pkg::red_ctrl_t               ctrl_o,
  output logic [bpc_pkg::CFG_BITS-1:0]     pmod_o
);

  localparam int CB       = bpc_pkg::CFG_BITS;
  localparam int StepBits = $clog2(CB + 1);

  logic                busy_q;
  logic [StepBits-1:0] step_q;
  logic [CB-1:0]       div_q;
  logic [CB-1:0]       red_q;
  logic [CB-1:0]       pmod_q;
  logic [CB:0]         trial;
  logic [CB:0]         trial_sub;

  assign ctrl_o.busy = busy_q;
  assign ctrl_o.load = busy_q && (step_q == '0);
  assign ctrl_o.last = busy_q && (step_q == StepBits'(CB));
  assign pmod_o      = pmod_q;

  // one restoring step per cycle
  assign trial     = {red_q, div_q[CB-1]};
  assign trial_sub = (trial >= {1'b0, held_i}) ? (trial - {1'b0, held_i}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      pmod_q <= bpc_pkg::PMOD_RESET;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + StepBits'(1);
      if (ctrl_o.last) begin
        busy_q <= 1'b0;
        pmod_q <= (held_i == '0) ? '0 : trial_sub[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_o.load) begin
      div_q <= poll_i;
      red_q <= '0;
    end else if (busy_q) begin
      div_q <= {div_q[CB-2:0], 1'b0};
      red_q <= trial_sub[CB-1:0];
    end
  end

endmodule

// ===== rtl/core/bpc_lane.sv =====
// one button lane: six-phase press machine, elapsed time and held remainder
module bpc_lane #(
  parameter int TimeBits = bpc_pkg::TIME_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                level_i,
  input  logic                edge_i,
  input  bpc_pkg::cfg_t       cfg_i,
  input  bpc_pkg::red_ctrl_t  ctrl_i,
  output bpc_pkg::event_e     event_o
);

  localparam int CB      = bpc_pkg::CFG_BITS;
  localparam int SumBits = ((TimeBits > CB) ? TimeBits : CB) + 1;
  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  bpc_pkg::phase_e     phase_q, phase_d;
  logic [TimeBits-1:0] elapsed_q, elapsed_d;
  // remainder as last stepped, and the same reduced by the current held_ms
  logic [CB-1:0]       rem_q, rem_d;
  logic [CB-1:0]       rem_red_q, rem_red_d;
  logic                rem_zero_q, rem_zero_d;
  logic                pend_q, pend_d;
  logic [CB-1:0]       div_q;
  logic [CB-1:0]       red_q;

  logic                pend;
  logic [SumBits-1:0]  t_ext;
  logic [SumBits-1:0]  t_sum;
  logic [TimeBits-1:0] t_add;
  logic                deb_done;
  logic                quick_done;
  logic                long_done;
  logic [CB:0]         rem_sum;
  logic [CB-1:0]       rem_next;
  logic [CB:0]         trial;
  logic [CB:0]         trial_sub;

  assign pend       = pend_q | edge_i;
  assign t_ext      = SumBits'(elapsed_q);
  assign t_sum      = t_ext + SumBits'(cfg_i.poll);
  assign t_add      = (t_sum > SumBits'(TimeMax)) ? TimeMax : t_sum[TimeBits-1:0];
  assign deb_done   = t_ext > SumBits'(cfg_i.debounce);
  assign quick_done = t_ext >= SumBits'(cfg_i.quick);
  assign long_done  = t_ext >= SumBits'(cfg_i.long_ms);

  // reduced remainder stays below held_ms, so one compare and subtract wraps it
  assign rem_sum  = {1'b0, rem_red_q} + {1'b0, cfg_i.pmod};
  assign rem_next = (cfg_i.held == '0) ? '0 :
                    (rem_sum >= {1'b0, cfg_i.held}) ?
                    CB'(rem_sum - {1'b0, cfg_i.held}) : rem_sum[CB-1:0];

  // serial reduction of the stored remainder after held_ms or poll_ms changes
  assign trial     = {red_q, div_q[CB-1]};
  assign trial_sub = (trial >= {1'b0, cfg_i.held}) ?
                     (trial - {1'b0, cfg_i.held}) : trial;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      case (phase_q)
        bpc_pkg::PH_IDLE: begin
          if (pend) phase_d = bpc_pkg::PH_DEB_PRESS;
        end
        bpc_pkg::PH_DEB_PRESS: begin
          if (deb_done) phase_d = bpc_pkg::PH_QUICK;
        end
        bpc_pkg::PH_QUICK: begin
          if (!level_i) phase_d = bpc_pkg::PH_DEB_REL;
          else if (quick_done) phase_d = bpc_pkg::PH_LONG;
        end
        bpc_pkg::PH_LONG: begin
          if (!level_i) phase_d = bpc_pkg::PH_DEB_REL;
          else if (long_done) phase_d = bpc_pkg::PH_HELD;
        end
        bpc_pkg::PH_HELD: begin
          if (!level_i) phase_d = bpc_pkg::PH_DEB_REL;
        end
        bpc_pkg::PH_DEB_REL: begin
          if (deb_done) phase_d = bpc_pkg::PH_IDLE;
        end
        default: phase_d = bpc_pkg::PH_IDLE;
      endcase
    end
  end

  // event and datapath
  always_comb begin
    event_o    = bpc_pkg::EV_NONE;
    elapsed_d  = elapsed_q;
    rem_d      = rem_q;
    rem_red_d  = rem_red_q;
    rem_zero_d = rem_zero_q;
    pend_d     = pend_q;
    if (ctrl_i.last) begin
      rem_red_d = (cfg_i.held == '0) ? '0 : trial_sub[CB-1:0];
    end
    if (step_i) begin
      pend_d = pend;
      case (phase_q)
        bpc_pkg::PH_IDLE: begin
          if (pend) elapsed_d = '0;
        end
        bpc_pkg::PH_DEB_PRESS: begin
          elapsed_d = deb_done ? '0 : t_add;
        end
        bpc_pkg::PH_QUICK: begin
          if (!level_i) begin
            event_o   = bpc_pkg::EV_QUICK;
            elapsed_d = '0;
          end else begin
            elapsed_d = quick_done ? '0 : t_add;
          end
        end
        bpc_pkg::PH_LONG: begin
          if (!level_i) begin
            event_o   = bpc_pkg::EV_QUICK;
            elapsed_d = '0;
          end else if (long_done) begin
            event_o    = bpc_pkg::EV_LONG;
            elapsed_d  = '0;
            rem_d      = '0;
            rem_red_d  = '0;
            rem_zero_d = 1'b1;
          end else begin
            elapsed_d = t_add;
          end
        end
        bpc_pkg::PH_HELD: begin
          if (!level_i) begin
            elapsed_d = '0;
          end else begin
            if (rem_zero_q) event_o = bpc_pkg::EV_HELD;
            elapsed_d  = t_add;
            rem_d      = rem_next;
            rem_red_d  = rem_next;
            rem_zero_d = (rem_next == '0);
          end
        end
        bpc_pkg::PH_DEB_REL: begin
          if (deb_done) begin
            event_o   = bpc_pkg::EV_RELEASE;
            elapsed_d = '0;
            pend_d    = 1'b0;
          end else begin
            elapsed_d = t_add;
          end
        end
        default: elapsed_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= bpc_pkg::PH_IDLE;
      elapsed_q  <= '0;
      rem_q      <= '0;
      rem_red_q  <= '0;
      rem_zero_q <= 1'b1;
      pend_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      rem_q      <= rem_d;
      rem_red_q  <= rem_red_d;
      rem_zero_q <= rem_zero_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      div_q <= rem_q;
      red_q <= '0;
    end else if (ctrl_i.busy) begin
      div_q <= {div_q[CB-2:0], 1'b0};
      red_q <= trial_sub[CB-1:0];
    end
  end

endmodule

// ===== rtl/core/bpc_merge.sv =====
// merging stage: gathers lane events into the output register
module bpc_merge (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          load_i,
  input  bpc_pkg::event_e [bpc_pkg::NUM_BUTTONS-1:0]   ev_i,
  input  logic                                          out_stall_i,
  output logic                                          out_valid_o,
  output bpc_pkg::out_beat_t                            out_data_o
);

  logic               valid_q;
  bpc_pkg::out_beat_t data_q;
  bpc_pkg::out_beat_t data_d;

  always_comb begin
    data_d.up_event    = bpc_pkg::EV_BITS'(ev_i[0]);
    data_d.enter_event = bpc_pkg::EV_BITS'(ev_i[1]);
    data_d.down_event  = bpc_pkg::EV_BITS'(ev_i[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
